@@ src/two_level_page_walker_defines.svh @@
// assertion helpers for the page walker
`ifndef TWO_LEVEL_PAGE_WALKER_DEFINES_SVH
`define TWO_LEVEL_PAGE_WALKER_DEFINES_SVH

// same-cycle implication
`define TLPW_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("page walker check failed");

// next-cycle implication
`define TLPW_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("page walker check failed");

`endif

@@ src/tlpw_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package tlpw_pkg;

   localparam logic [31:0] BASE_RESET = 32'h0003_9000;
   localparam logic [12:0] PAGE_BYTES = 13'h1000;
   localparam int PRESENT_BIT = 0;
   localparam int LARGE_BIT = 7;

   typedef enum logic [1:0] {
      KIND_READ    = 2'd0,
      KIND_DONE    = 2'd1,
      KIND_FAULT   = 2'd2,
      KIND_IGNORED = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      PHASE_IDLE  = 2'd0,
      PHASE_DIR   = 2'd1,
      PHASE_TABLE = 2'd2
   } phase_type;

   typedef struct packed {
      logic        command;
      logic [31:0] virt_addr;
      logic [31:0] length;
      logic [31:0] read_data;
   } req_type;

   typedef struct packed {
      kind_type    kind;
      logic [31:0] mem_addr;
      logic [31:0] phys_addr;
      logic [12:0] clipped_length;
   } rsp_type;

endpackage

`default_nettype wire

@@ src/two_level_page_walker.sv @@
// throughput: one item per cycle while the skid register is empty, set
// by the single pass of entry decode and page-end clipping between the
// request port and the result register
// a two-entry result buffer keeps the request side open while a result waits
// reset: synchronous active high, walker idle, directory base 0x39000
`timescale 1ns / 1ps
`default_nettype none

module two_level_page_walker (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire tlpw_pkg::req_type req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output tlpw_pkg::rsp_type      rsp_data,
   input  wire logic              csr_write_enable,
   input  wire logic [31:0]       csr_write_data
);

   logic              req_accept;
   tlpw_pkg::rsp_type result;

   assign req_accept = req_valid && req_ready;

   tlpw_walk_core u_core (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req_accept       (req_accept),
      .req_data         (req_data),
      .result           (result)
   );

   tlpw_rsp_buffer u_rsp_buffer (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .in_data   (result),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_data  (rsp_data)
   );

endmodule

`default_nettype wire

@@ src/tlpw_walk_core.sv @@
`timescale 1ns / 1ps
`default_nettype none

`include "two_level_page_walker_defines.svh"

module tlpw_walk_core (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             csr_write_enable,
   input  wire logic [31:0]      csr_write_data,
   input  wire logic             req_accept,
   input  wire tlpw_pkg::req_type req_data,
   output tlpw_pkg::rsp_type     result
);

   tlpw_pkg::phase_type phase_ff, phase_in;
   logic [31:0] base_ff;
   logic [31:0] held_vaddr_ff, held_vaddr_in;
   logic [31:0] held_length_ff, held_length_in;

   logic        busy;
   logic [31:0] paddr;
   logic [11:0] offset;
   logic [12:0] room;
   logic        clip;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= tlpw_pkg::PHASE_IDLE;
         base_ff        <= tlpw_pkg::BASE_RESET;
         held_vaddr_ff  <= '0;
         held_length_ff <= '0;
      end else begin
         phase_ff       <= phase_in;
         held_vaddr_ff  <= held_vaddr_in;
         held_length_ff <= held_length_in;
         if (csr_write_enable) begin
            base_ff <= csr_write_data;
         end
      end
   end

   // physical address of a finished walk, large or small page
   always_comb begin
      if (phase_ff == tlpw_pkg::PHASE_DIR) begin
         paddr = {req_data.read_data[31:22], held_vaddr_ff[21:0]};
      end else begin
         paddr = {req_data.read_data[31:12], held_vaddr_ff[11:0]};
      end
      offset = paddr[11:0];
      room   = tlpw_pkg::PAGE_BYTES - {1'b0, offset};
      clip   = held_length_ff > {19'd0, room};
   end

   always_comb begin
      busy           = (phase_ff == tlpw_pkg::PHASE_DIR) || (phase_ff == tlpw_pkg::PHASE_TABLE);
      phase_in       = phase_ff;
      held_vaddr_in  = held_vaddr_ff;
      held_length_in = held_length_ff;
      result         = '{kind: tlpw_pkg::KIND_IGNORED, mem_addr: '0, phys_addr: '0,
                         clipped_length: '0};
      if (req_accept) begin
         if (!req_data.command) begin
            if (!busy) begin
               phase_in = tlpw_pkg::PHASE_IDLE;
               if (base_ff[11:0] != 12'd0) begin
                  result.kind = tlpw_pkg::KIND_FAULT;
               end else begin
                  held_vaddr_in   = req_data.virt_addr;
                  held_length_in  = req_data.length;
                  phase_in        = tlpw_pkg::PHASE_DIR;
                  result.kind     = tlpw_pkg::KIND_READ;
                  result.mem_addr = {base_ff[31:12], req_data.virt_addr[31:22], 2'b00};
               end
            end
         end else if (busy) begin
            if (!req_data.read_data[tlpw_pkg::PRESENT_BIT]) begin
               phase_in    = tlpw_pkg::PHASE_IDLE;
               result.kind = tlpw_pkg::KIND_FAULT;
            end else if ((phase_ff == tlpw_pkg::PHASE_DIR)
                         && !req_data.read_data[tlpw_pkg::LARGE_BIT]) begin
               phase_in        = tlpw_pkg::PHASE_TABLE;
               result.kind     = tlpw_pkg::KIND_READ;
               result.mem_addr = {req_data.read_data[31:12], held_vaddr_ff[21:12], 2'b00};
            end else begin
               phase_in              = tlpw_pkg::PHASE_IDLE;
               result.kind           = tlpw_pkg::KIND_DONE;
               result.phys_addr      = paddr;
               result.clipped_length = clip ? room : held_length_ff[12:0];
            end
         end
      end
   end

   `TLPW_ASSERT_NEXT(a_read_starts_walk, clock, reset,
      req_accept && (result.kind == tlpw_pkg::KIND_READ),
      phase_ff != tlpw_pkg::PHASE_IDLE)
   `TLPW_ASSERT_NEXT(a_end_goes_idle, clock, reset,
      req_accept && ((result.kind == tlpw_pkg::KIND_DONE) || (result.kind == tlpw_pkg::KIND_FAULT)),
      phase_ff == tlpw_pkg::PHASE_IDLE)
   `TLPW_ASSERT_NOW(a_done_within_page, clock, reset,
      req_accept && (result.kind == tlpw_pkg::KIND_DONE),
      ({1'b0, result.phys_addr[11:0]} + result.clipped_length) <= tlpw_pkg::PAGE_BYTES)

endmodule

`default_nettype wire

@@ src/tlpw_rsp_buffer.sv @@
`timescale 1ns / 1ps
`default_nettype none

module tlpw_rsp_buffer (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              in_valid,
   output logic                   in_ready,
   input  wire tlpw_pkg::rsp_type in_data,
   output logic                   out_valid,
   input  wire logic              out_ready,
   output tlpw_pkg::rsp_type      out_data
);

   logic              out_valid_ff, out_valid_in;
   tlpw_pkg::rsp_type out_data_ff, out_data_in;
   logic              skid_valid_ff, skid_valid_in;
   tlpw_pkg::rsp_type skid_data_ff, skid_data_in;
   logic              push;
   logic              pop;

   assign in_ready  = !skid_valid_ff;
   assign out_valid = out_valid_ff;
   assign out_data  = out_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

   always_comb begin
      push          = in_valid && in_ready;
      pop           = out_valid_ff && out_ready;
      out_valid_in  = out_valid_ff;
      out_data_in   = out_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (pop || !out_valid_ff) begin
         if (skid_valid_ff) begin
            out_valid_in  = 1'b1;
            out_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end else begin
            out_valid_in = push;
            out_data_in  = in_data;
         end
      end else if (push) begin
         // result still waiting, park the new item
         skid_valid_in = 1'b1;
         skid_data_in  = in_data;
      end
   end

endmodule

`default_nettype wire

@@ sim/tlpw_test_pkg.sv @@
`timescale 1ns / 1ps

package tlpw_test_pkg;

   localparam logic CMD_TRANSLATE = 1'b0;
   localparam logic CMD_RESPONSE  = 1'b1;

endpackage

@@ sim/two_level_page_walker_checker.sv @@
`timescale 1ns / 1ps

module two_level_page_walker_checker (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   input  wire logic              req_ready,
   input  wire tlpw_pkg::req_type req_data,
   input  wire logic              rsp_valid,
   input  wire logic              rsp_ready,
   input  wire tlpw_pkg::rsp_type rsp_data,
   input  wire logic              csr_write_enable,
   input  wire logic [31:0]       csr_write_data,
   output int                     mismatch_count,
   output int                     pending_count
);
   import tlpw_pkg::*;
   import tlpw_test_pkg::*;

   localparam int REPORT_LIMIT = 10;

   logic [31:0] dir_base;
   phase_type   walk_phase;
   logic [31:0] held_vaddr;
   logic [31:0] held_length;
   rsp_type     due_results[$];
   int          errors;

   initial begin
      errors = 0;
      mismatch_count = 0;
      pending_count = 0;
   end

   function automatic rsp_type page_done(input logic [31:0] paddr);
      rsp_type     outcome;
      logic [32:0] span;
      outcome = '0;
      outcome.kind = KIND_DONE;
      outcome.phys_addr = paddr;
      span = {21'b0, paddr[11:0]} + {1'b0, held_length};
      if (span > 33'(PAGE_BYTES)) begin
         outcome.clipped_length = PAGE_BYTES - {1'b0, paddr[11:0]};
      end else begin
         outcome.clipped_length = held_length[12:0];
      end
      walk_phase = PHASE_IDLE;
      return outcome;
   endfunction

   function automatic rsp_type walk_response(input req_type item);
      rsp_type outcome;
      logic    busy;
      outcome = '0;
      outcome.kind = KIND_IGNORED;
      busy = (walk_phase == PHASE_DIR) || (walk_phase == PHASE_TABLE);
      if (item.command == CMD_TRANSLATE) begin
         if (!busy) begin
            walk_phase = PHASE_IDLE;
            if (dir_base[11:0] != 12'h000) begin
               outcome.kind = KIND_FAULT;
            end else begin
               held_vaddr = item.virt_addr;
               held_length = item.length;
               walk_phase = PHASE_DIR;
               outcome.kind = KIND_READ;
               outcome.mem_addr = dir_base + {20'b0, item.virt_addr[31:22], 2'b00};
            end
         end
      end else if (busy) begin
         if (!item.read_data[PRESENT_BIT]) begin
            walk_phase = PHASE_IDLE;
            outcome.kind = KIND_FAULT;
         end else if (walk_phase == PHASE_DIR && item.read_data[LARGE_BIT]) begin
            outcome = page_done({item.read_data[31:22], held_vaddr[21:0]});
         end else if (walk_phase == PHASE_DIR) begin
            walk_phase = PHASE_TABLE;
            outcome.kind = KIND_READ;
            outcome.mem_addr = {item.read_data[31:12], 12'h000}
                               + {20'b0, held_vaddr[21:12], 2'b00};
         end else begin
            outcome = page_done({item.read_data[31:12], held_vaddr[11:0]});
         end
      end
      return outcome;
   endfunction

   always @(posedge clock) begin
      rsp_type wanted;
      if (reset) begin
         dir_base = BASE_RESET;
         walk_phase = PHASE_IDLE;
         held_vaddr = '0;
         held_length = '0;
         due_results.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (due_results.size() == 0) begin
               if (errors < REPORT_LIMIT) begin
                  $display("unexpected result: kind %0d mem %h phys %h len %0d",
                           rsp_data.kind, rsp_data.mem_addr, rsp_data.phys_addr,
                           rsp_data.clipped_length);
               end
               errors++;
            end else begin
               wanted = due_results.pop_front();
               if (rsp_data.kind !== wanted.kind || rsp_data.mem_addr !== wanted.mem_addr
                   || rsp_data.phys_addr !== wanted.phys_addr
                   || rsp_data.clipped_length !== wanted.clipped_length) begin
                  if (errors < REPORT_LIMIT) begin
                     $display("mismatch: expected kind %0d mem %h phys %h len %0d",
                              wanted.kind, wanted.mem_addr, wanted.phys_addr,
                              wanted.clipped_length);
                     $display("          actual   kind %0d mem %h phys %h len %0d",
                              rsp_data.kind, rsp_data.mem_addr, rsp_data.phys_addr,
                              rsp_data.clipped_length);
                  end
                  errors++;
               end
            end
         end
         if (csr_write_enable) begin
            dir_base = csr_write_data;
         end
         if (req_valid && req_ready) begin
            due_results.push_back(walk_response(req_data));
         end
      end
      mismatch_count <= errors;
      pending_count <= due_results.size();
   end

endmodule

@@ sim/two_level_page_walker_test.sv @@
`timescale 1ns / 1ps

module two_level_page_walker_test;
   import tlpw_pkg::*;
   import tlpw_test_pkg::*;

   localparam int IDLE_LIMIT = 2000;
   localparam int HOLD_CYCLES = 200;
   localparam int WALK_ITEMS = 262;
   localparam int SHORT_ITEMS = 40;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   req_type     req_data = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   rsp_type     rsp_data;
   logic        csr_write_enable = 1'b0;
   logic [31:0] csr_write_data = '0;

   int mismatch_count;
   int pending_count;
   int idle_cycles = 0;
   bit sender_eager = 1'b0;
   bit receiver_eager = 1'b0;

   always #5 clock = ~clock;

   two_level_page_walker dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data(rsp_data),
      .csr_write_enable(csr_write_enable),
      .csr_write_data(csr_write_data)
   );

   two_level_page_walker_checker walk_check (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data(rsp_data),
      .csr_write_enable(csr_write_enable),
      .csr_write_data(csr_write_data),
      .mismatch_count(mismatch_count),
      .pending_count(pending_count)
   );

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles == IDLE_LIMIT) begin
         $display("two_level_page_walker test failed");
         $finish;
      end
   end

   task automatic send_item(input logic command, input logic [31:0] vaddr,
                            input logic [31:0] len, input logic [31:0] entry);
      int gap;
      if ($urandom_range(0, 47) == 0) begin
         sender_eager = !sender_eager;
      end
      gap = sender_eager ? 0 : $urandom_range(0, 7);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= '{command: command, virt_addr: vaddr, length: len, read_data: entry};
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic write_base(input logic [31:0] value);
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_count != 0);
      repeat (3) @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   // mostly whole walks with random content, a few stray items between them
   task automatic run_walks(input int count);
      int          sent;
      logic [31:0] vaddr;
      logic [31:0] len;
      logic [31:0] entry;
      sent = 0;
      while (sent < count) begin
         if ($urandom_range(0, 9) == 0) begin
            send_item(1'($urandom_range(0, 1)), $urandom, $urandom, $urandom);
         end else begin
            vaddr = $urandom;
            case ($urandom_range(0, 7))
               0: len = 32'h0;
               1: len = $urandom_range(1, 16);
               2: len = $urandom_range(0, 4096);
               3: len = 32'h1000 - vaddr[11:0];
               4: len = 32'h1001 - vaddr[11:0];
               5: len = 32'hffff_ffff;
               default: len = $urandom;
            endcase
            send_item(CMD_TRANSLATE, vaddr, len, $urandom);
            entry = $urandom;
            entry[PRESENT_BIT] = ($urandom_range(0, 7) != 0);
            entry[LARGE_BIT] = ($urandom_range(0, 2) == 0);
            send_item(CMD_RESPONSE, $urandom, $urandom, entry);
            sent += 2;
            if (entry[PRESENT_BIT] && !entry[LARGE_BIT]) begin
               entry = $urandom;
               entry[PRESENT_BIT] = ($urandom_range(0, 7) != 0);
               send_item(CMD_RESPONSE, $urandom, $urandom, entry);
               sent++;
            end
         end
      end
   endtask

   initial begin : result_sink
      int gap;
      int taken;
      taken = 0;
      do @(posedge clock); while (reset);
      forever begin
         // long hold-off so the block fills and stalls its input
         if (taken == 300 || taken == 900) begin
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
         if ($urandom_range(0, 63) == 0) begin
            receiver_eager = !receiver_eager;
         end
         gap = receiver_eager ? 0 : $urandom_range(0, 7);
         if (gap != 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
         taken++;
      end
   end

   initial begin
      logic [31:0] base_value;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      send_item(CMD_RESPONSE, 32'h0, 32'h0, 32'hffff_ffff);
      send_item(CMD_TRANSLATE, 32'h0, 32'h0, 32'h0);
      send_item(CMD_TRANSLATE, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
      send_item(CMD_RESPONSE, 32'h0, 32'h0, 32'hffff_fffe);
      send_item(CMD_TRANSLATE, 32'hffff_ffff, 32'hffff_ffff, 32'h0);
      send_item(CMD_RESPONSE, 32'h0, 32'h0, 32'hffff_ffff);
      send_item(CMD_TRANSLATE, 32'h0040_0000, 32'h0000_1000, 32'h0);
      send_item(CMD_RESPONSE, 32'h0, 32'h0, 32'h1234_5001);
      send_item(CMD_RESPONSE, 32'h0, 32'h0, 32'h0);
      send_item(CMD_TRANSLATE, 32'habcd_ef00, 32'h0000_0100, 32'h0);
      send_item(CMD_RESPONSE, 32'h0, 32'h0, 32'hffff_f07f);
      send_item(CMD_RESPONSE, 32'h0, 32'h0, 32'hffff_ffff);
      send_item(CMD_TRANSLATE, 32'h0000_0fff, 32'h0000_0001, 32'h0);
      send_item(CMD_RESPONSE, 32'h0, 32'h0, 32'h0000_0081);
      send_item(CMD_TRANSLATE, 32'h1234_5678, 32'h0000_1000, 32'h0);
      send_item(CMD_RESPONSE, 32'h0, 32'h0, 32'h0000_0001);
      send_item(CMD_RESPONSE, 32'h0, 32'h0, 32'h0000_0001);
      send_item(CMD_TRANSLATE, 32'h0, 32'h0000_1000, 32'h0);
      send_item(CMD_RESPONSE, 32'h0, 32'h0, 32'h8000_0081);
      send_item(CMD_TRANSLATE, 32'h0, 32'h0000_1001, 32'h0);
      send_item(CMD_RESPONSE, 32'h0, 32'h0, 32'h0000_0001);
      send_item(CMD_RESPONSE, 32'h0, 32'h0, 32'h0000_0001);

      run_walks(WALK_ITEMS);
      write_base(32'h0000_0000);
      run_walks(WALK_ITEMS);
      write_base(32'hffff_f000);
      run_walks(WALK_ITEMS);
      // unaligned base: a translate that finds the walker idle faults at once
      write_base(32'hffff_ffff);
      run_walks(SHORT_ITEMS);
      base_value = $urandom;
      base_value[11:0] = 12'h000;
      write_base(base_value);
      run_walks(WALK_ITEMS);
      write_base(32'h0000_0800);
      run_walks(SHORT_ITEMS);
      write_base(BASE_RESET);
      run_walks(WALK_ITEMS);

      req_valid <= 1'b0;
      do @(posedge clock); while (pending_count != 0);
      repeat (4) @(posedge clock);
      if (mismatch_count == 0 && pending_count == 0) begin
         $display("two_level_page_walker test passed");
      end else begin
         $display("two_level_page_walker test failed");
      end
      $finish;
   end

endmodule
